@@ hw/rtl/jdn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdn_pkg
// Shared types and constants for the joystick dead-zone normalizer.
// ----------------------------------------------------------------------------
package jdn_pkg;

  // result format: signed Q1.15
  localparam int POS_W  = 16;
  localparam int Q_FRAC = 15;

  localparam logic signed [POS_W-1:0] POS_FULL     = 16'sd32767;
  localparam logic signed [POS_W-1:0] POS_NEG_FULL = -16'sd32767;
  localparam logic signed [POS_W-1:0] POS_ZERO     = 16'sd0;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_FULL_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNREACHABLE_BAND = 2'd2;

  // input item kinds
  localparam logic KIND_CAL    = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_CAL_WAIT,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } jdn_state_e;

endpackage

@@ hw/rtl/jdn_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdn_div
// Bit-serial restoring divider, one quotient bit per cycle. The partial
// remainder is preloaded (it must stay below the divisor) and the numerator
// bits shift in msb first.
// ----------------------------------------------------------------------------
module jdn_div #(
  parameter int DW = 13,
  parameter int NW = 17,
  parameter int QW = 17,
  parameter int CW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [CW-1:0] steps_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o
);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] den_q, den_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = rem_i;
      num_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so dropping the top bit is safe
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      num_d = {num_q[NW-2:0], 1'b0};
      quo_d = {quo_q[QW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ hw/rtl/joystick_deadzone_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_deadzone_normalizer
// Two-axis joystick dead-zone removal and Q1.15 normalization.
// ----------------------------------------------------------------------------
// Input beats carry a kind bit and one ADC reading per axis. A calibration
// beat adds both readings to running sums; after CAL_SAMPLES of them each
// center becomes its sum divided by CAL_SAMPLES. An update beat yields one
// output beat with the normalized x and y positions.
// Both data channels use valid/stall; the config channel uses valid/ready,
// is always ready, and should only be written while the block is idle.
// Timing: all division runs through one bit-serial divider, one bit a cycle.
// An update beat runs a setup step per axis, plus a divider run for each axis
// that lands outside the dead band and the clamp; the result then moves to
// the output register once that is free. A calibration beat only adds to the
// sums, except the last of a set, which runs two divisions of
// ADC_BITS+log2(CAL_SAMPLES) quotient bits each.
// One item is in flight at a time; a new input beat is taken while a result
// still waits in the output register, which holds under stall.
// Reset: centers go to mid scale, sums and count clear, deadzone 64,
// full scale all ones, unreachable band 0.
// ----------------------------------------------------------------------------
module joystick_deadzone_normalizer #(
  parameter int ADC_BITS    = 12,
  parameter int CAL_SAMPLES = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [jdn_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ADC_BITS-1:0]                cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [ADC_BITS-1:0]                x_sample_i,
  input  logic [ADC_BITS-1:0]                y_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [jdn_pkg::POS_W-1:0]   x_position_o,
  output logic signed [jdn_pkg::POS_W-1:0]   y_position_o
);

  import jdn_pkg::*;

  localparam int A     = ADC_BITS;
  localparam int CNT_W = $clog2(CAL_SAMPLES);
  localparam int SW    = ADC_BITS + $clog2(CAL_SAMPLES);
  localparam int DW    = ADC_BITS + 1;
  localparam int QW    = (SW > Q_FRAC) ? SW : Q_FRAC;
  localparam int SCW   = $clog2(QW + 1);
  localparam int SPW   = ADC_BITS + 3;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  jdn_state_e state_q, state_d;
  logic       axis_q, axis_d;
  logic       neg_q, neg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SW-1:0]    sum_q    [2];
  logic [SW-1:0]    sum_d    [2];
  logic [A-1:0]     center_q [2];
  logic [A-1:0]     center_d [2];
  logic [A-1:0]     samp_q   [2];
  logic [A-1:0]     samp_d   [2];
  logic signed [POS_W-1:0] res_q [2];
  logic signed [POS_W-1:0] res_d [2];
  logic [A-1:0] dz_q, fs_q, ub_q;
  logic         out_valid_q, out_valid_d;
  logic signed [POS_W-1:0] xo_q, xo_d, yo_q, yo_d;

  // divider hookup
  logic           div_start;
  logic [DW-1:0]  div_rem;
  logic [SW-1:0]  div_num;
  logic [DW-1:0]  div_den;
  logic [SCW-1:0] div_steps;
  logic           div_done;
  logic [QW-1:0]  div_quo;
  logic [POS_W-1:0] div_mag;

  // per-axis setup terms
  logic [A-1:0]          ax_s, ax_c;
  logic [A:0]            ax_d;
  logic                  ax_neg;
  logic [A:0]            ax_abs;
  logic [A-1:0]          ax_mag;
  logic                  ax_in_band;
  logic [A-1:0]          ax_e;
  logic signed [SPW-1:0] span_pos, span_neg, ax_span;
  logic                  ax_zero, ax_clamp;

  assign ax_s   = samp_q[axis_q];
  assign ax_c   = center_q[axis_q];
  assign ax_d   = {1'b0, ax_s} - {1'b0, ax_c};
  assign ax_neg = ax_d[A];
  assign ax_abs = ax_neg ? (~ax_d + 1'b1) : ax_d;
  assign ax_mag = ax_abs[A-1:0];
  assign ax_in_band = (ax_mag <= dz_q);
  assign ax_e   = ax_mag - dz_q;

  assign span_pos = $signed({3'b000, fs_q}) - $signed({3'b000, ub_q})
                  - $signed({3'b000, ax_c}) - $signed({3'b000, dz_q});
  assign span_neg = $signed({3'b000, ax_c}) - $signed({3'b000, dz_q});
  assign ax_span  = ax_neg ? span_neg : span_pos;

  // a non-negative span never exceeds full scale, so its low bits hold it
  assign ax_zero  = ax_in_band || ax_span[SPW-1];
  assign ax_clamp = (ax_e >= ax_span[A-1:0]);

  assign div_mag = POS_W'({1'b0, div_quo[Q_FRAC-1:0]});

  jdn_div #(
    .DW (DW),
    .NW (SW),
    .QW (QW),
    .CW (SCW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    center_d    = center_q;
    samp_d      = samp_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    xo_d        = xo_q;
    yo_d        = yo_q;
    div_start   = 1'b0;
    div_rem     = '0;
    div_num     = '0;
    div_den     = '0;
    div_steps   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == KIND_CAL) begin
            sum_d[0] = sum_q[0] + SW'(x_sample_i);
            sum_d[1] = sum_q[1] + SW'(y_sample_i);
            if (cnt_q == CNT_W'(CAL_SAMPLES - 1)) begin
              cnt_d   = '0;
              axis_d  = AXIS_X;
              state_d = ST_CAL;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end else begin
            samp_d[0] = x_sample_i;
            samp_d[1] = y_sample_i;
            axis_d    = AXIS_X;
            state_d   = ST_SETUP;
          end
        end
      end
      ST_CAL: begin
        div_start = 1'b1;
        div_num   = sum_q[axis_q];
        div_den   = DW'(CAL_SAMPLES);
        div_steps = SCW'(SW);
        state_d   = ST_CAL_WAIT;
      end
      ST_CAL_WAIT: begin
        if (div_done) begin
          center_d[axis_q] = div_quo[A-1:0];
          if (axis_q == AXIS_X) begin
            axis_d  = AXIS_Y;
            state_d = ST_CAL;
          end else begin
            sum_d[0] = '0;
            sum_d[1] = '0;
            state_d  = ST_IDLE;
          end
        end
      end
      ST_SETUP: begin
        neg_d = ax_neg;
        if (ax_zero || ax_clamp) begin
          if (ax_zero) begin
            res_d[axis_q] = POS_ZERO;
          end else begin
            res_d[axis_q] = ax_neg ? POS_NEG_FULL : POS_FULL;
          end
          if (axis_q == AXIS_X) begin
            axis_d = AXIS_Y;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          // e < span here, so the quotient fits in Q_FRAC bits
          div_start = 1'b1;
          div_rem   = DW'(ax_e);
          div_den   = DW'(ax_span[A-1:0]);
          div_steps = SCW'(Q_FRAC);
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_d[axis_q] = neg_q ? -$signed(div_mag) : $signed(div_mag);
          if (axis_q == AXIS_X) begin
            axis_d  = AXIS_Y;
            state_d = ST_SETUP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          xo_d        = res_q[0];
          yo_d        = res_q[1];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AXIS_X;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      center_q[0] <= A'(1) << (A - 1);
      center_q[1] <= A'(1) << (A - 1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      center_q    <= center_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= samp_d;
    res_q  <= res_d;
    xo_q   <= xo_d;
    yo_q   <= yo_d;
  end

  // config registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= A'(64);
      fs_q <= '1;
      ub_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEADZONE:         dz_q <= cfg_data_i;
        CFG_ADC_FULL_SCALE:   fs_q <= cfg_data_i;
        CFG_UNREACHABLE_BAND: ub_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign x_position_o = xo_q;
  assign y_position_o = yo_q;

endmodule

@@ bench/joystick_deadzone_normalizer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_deadzone_normalizer_checker
// Watches the config, input and output channels of the normalizer, keeps its
// own copy of the calibration state and registers, predicts the position of
// every update beat and compares each output beat against the oldest one.
// ----------------------------------------------------------------------------
module joystick_deadzone_normalizer_checker #(
  parameter int ADC_BITS    = 12,
  parameter int CAL_SAMPLES = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [jdn_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ADC_BITS-1:0]                cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic                               kind_i,
  input  logic [ADC_BITS-1:0]                x_sample_i,
  input  logic [ADC_BITS-1:0]                y_sample_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [jdn_pkg::POS_W-1:0]   x_position_i,
  input  logic signed [jdn_pkg::POS_W-1:0]   y_position_i,
  output int                                 pending_o,
  output int                                 fails_o,
  output int                                 results_o
);

  import jdn_pkg::*;

  localparam logic [ADC_BITS-1:0] RST_DEADZONE   = ADC_BITS'(64);
  localparam logic [ADC_BITS-1:0] RST_FULL_SCALE = {ADC_BITS{1'b1}};
  localparam logic [ADC_BITS-1:0] RST_BAND       = '0;
  localparam logic [ADC_BITS-1:0] MID_SCALE      = ADC_BITS'(1) << (ADC_BITS - 1);
  localparam longint Q_ONE       = longint'(1) << Q_FRAC;
  localparam int     MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } position_t;

  logic [ADC_BITS-1:0] deadzone;
  logic [ADC_BITS-1:0] full_scale;
  logic [ADC_BITS-1:0] band;
  logic [ADC_BITS-1:0] rest_ctr_x;
  logic [ADC_BITS-1:0] rest_ctr_y;
  int                  sum_x;
  int                  sum_y;
  int                  cal_count;
  int                  fails;
  int                  results;
  position_t           position_q[$];
  position_t           want;
  position_t           got;

  // dead band removal and scaling of one axis against its own center
  function automatic logic signed [POS_W-1:0] axis_position(
    input logic [ADC_BITS-1:0] sample,
    input logic [ADC_BITS-1:0] center,
    input logic [ADC_BITS-1:0] dz,
    input logic [ADC_BITS-1:0] fs,
    input logic [ADC_BITS-1:0] ub
  );
    longint d;
    longint mag;
    longint span;
    longint q;
    d   = longint'(sample) - longint'(center);
    mag = (d < 0) ? -d : d;
    if (mag <= longint'(dz)) return POS_ZERO;
    if (d > 0) begin
      span = longint'(fs) - longint'(ub) - longint'(center) - longint'(dz);
    end else begin
      span = longint'(center) - longint'(dz);
    end
    if (span < 0) return POS_ZERO;
    // no travel left past the dead band: full deflection
    if (span == 0) begin
      q = longint'(POS_FULL);
    end else begin
      q = (mag - longint'(dz)) * Q_ONE / span;
      if (q > longint'(POS_FULL)) q = longint'(POS_FULL);
    end
    return (d > 0) ? POS_W'(q) : POS_W'(-q);
  endfunction

  task automatic note_mismatch(input string what, input position_t exp_pos,
                               input position_t act_pos);
    fails++;
    if (fails <= MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected x=%0d y=%0d, got x=%0d y=%0d", $time, what,
               exp_pos.x, exp_pos.y, act_pos.x, act_pos.y);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone   = RST_DEADZONE;
      full_scale = RST_FULL_SCALE;
      band       = RST_BAND;
      rest_ctr_x = MID_SCALE;
      rest_ctr_y = MID_SCALE;
      sum_x      = 0;
      sum_y      = 0;
      cal_count  = 0;
      position_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DEADZONE:         deadzone   = cfg_data_i;
          CFG_ADC_FULL_SCALE:   full_scale = cfg_data_i;
          CFG_UNREACHABLE_BAND: band       = cfg_data_i;
          default: ;
        endcase
      end

      // retire the oldest expectation before queuing a new one
      if (out_valid_i && !out_stall_i) begin
        got.x = x_position_i;
        got.y = y_position_i;
        results++;
        if (position_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("%0t: unexpected output beat x=%0d y=%0d", $time, got.x, got.y);
          end
        end else begin
          want = position_q.pop_front();
          if (got.x !== want.x) note_mismatch("x_position", want, got);
          if (got.y !== want.y) note_mismatch("y_position", want, got);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (kind_i == KIND_CAL) begin
          sum_x += int'(x_sample_i);
          sum_y += int'(y_sample_i);
          cal_count++;
          if (cal_count >= CAL_SAMPLES) begin
            rest_ctr_x = ADC_BITS'(sum_x / CAL_SAMPLES);
            rest_ctr_y = ADC_BITS'(sum_y / CAL_SAMPLES);
            sum_x      = 0;
            sum_y      = 0;
            cal_count  = 0;
          end
        end else begin
          want.x = axis_position(x_sample_i, rest_ctr_x, deadzone, full_scale, band);
          want.y = axis_position(y_sample_i, rest_ctr_y, deadzone, full_scale, band);
          position_q.push_back(want);
        end
      end

      pending_o <= position_q.size();
    end
  end

  always @(posedge clk_i) begin
    fails_o   <= fails;
    results_o <= results;
  end

endmodule

@@ bench/joystick_deadzone_normalizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_deadzone_normalizer_test
// Drives directed and random calibration and update beats through the
// normalizer under random idle gaps and output stalls, across several
// register settings; the checker beside the block scores every output beat.
// ----------------------------------------------------------------------------
module joystick_deadzone_normalizer_test;
  import jdn_pkg::*;

  localparam int ADC_BITS     = 12;
  localparam int CAL_SAMPLES  = 32;
  localparam int ADC_MAX      = (1 << ADC_BITS) - 1;
  localparam int MID          = 1 << (ADC_BITS - 1);
  localparam int SETTLE_TICKS = 80;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 60;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index    = CFG_DEADZONE;
  logic [ADC_BITS-1:0]     cfg_data     = '0;
  logic                    in_valid     = 1'b0;
  logic                    kind         = KIND_CAL;
  logic [ADC_BITS-1:0]     x_sample     = '0;
  logic [ADC_BITS-1:0]     y_sample     = '0;
  logic                    out_stall    = 1'b0;
  logic                    cfg_ready;
  logic                    in_stall;
  logic                    out_valid;
  logic signed [POS_W-1:0] x_position;
  logic signed [POS_W-1:0] y_position;

  int pending;
  int fails;
  int results;
  int beats;
  int cal_beats;
  int settings;
  int dz_now;
  bit steady;
  int stall_left;
  int calm_left;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  joystick_deadzone_normalizer #(
    .ADC_BITS    (ADC_BITS),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .x_sample_i   (x_sample),
    .y_sample_i   (y_sample),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .x_position_o (x_position),
    .y_position_o (y_position)
  );

  joystick_deadzone_normalizer_checker #(
    .ADC_BITS    (ADC_BITS),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .kind_i       (kind),
    .x_sample_i   (x_sample),
    .y_sample_i   (y_sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .x_position_i (x_position),
    .y_position_i (y_position),
    .pending_o    (pending),
    .fails_o      (fails),
    .results_o    (results)
  );

  // output back-pressure: short and long stalls, with calm stretches between
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
      case ($urandom_range(0, 9))
        0:          stall_left = $urandom_range(20, 60);
        1, 2, 3, 4: stall_left = $urandom_range(1, 3);
        9:          calm_left  = $urandom_range(50, 200);
        default:    calm_left  = $urandom_range(1, 10);
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADC_BITS-1:0] to_sample(input int v);
    if (v < 0) return '0;
    if (v > ADC_MAX) return ADC_BITS'(ADC_MAX);
    return ADC_BITS'(v);
  endfunction

  function automatic int pick_reg(input int lo, input int hi);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return ADC_MAX;
      2:       return $urandom_range(0, ADC_MAX);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // half spread over the range, the rest near the rest point, on the dead band edges and end stops
  function automatic logic [ADC_BITS-1:0] pick_sample(input int rest);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ADC_BITS'(ADC_MAX);
      2:       return to_sample(rest + ($urandom_range(0, 1) ? dz_now : -dz_now)
                                + $urandom_range(0, 4) - 2);
      3:       return to_sample(rest + $urandom_range(0, 60) - 30);
      default: return ADC_BITS'($urandom_range(0, ADC_MAX));
    endcase
  endfunction

  task automatic send_item(input logic k, input logic [ADC_BITS-1:0] xs,
                           input logic [ADC_BITS-1:0] ys);
    int gap;
    in_valid <= 1'b1;
    kind     <= k;
    x_sample <= xs;
    y_sample <= ys;
    do @(posedge clk); while (in_stall);
    beats++;
    if (k == KIND_CAL) cal_beats++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain every expected beat, then give a trailing calibration division time
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ADC_BITS'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input int dz, input int fs, input int ub);
    settle();
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_ADC_FULL_SCALE, fs);
    write_reg(CFG_UNREACHABLE_BAND, ub);
    cfg_valid <= 1'b0;
    dz_now = dz;
    settings++;
  endtask

  initial begin
    int rest_x;
    int rest_y;
    int count;
    int n;
    bit paused;
    dz_now = 64;
    rest_x = MID;
    rest_y = MID;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, centers at mid scale
    send_item(KIND_UPDATE, 12'd2048, 12'd2048);
    send_item(KIND_UPDATE, 12'd0, 12'd4095);
    send_item(KIND_UPDATE, 12'd4095, 12'd0);
    send_item(KIND_UPDATE, 12'd2112, 12'd1984);
    send_item(KIND_UPDATE, 12'd2113, 12'd1983);
    send_item(KIND_UPDATE, 12'hAAA, 12'h555);
    send_item(KIND_UPDATE, 12'h555, 12'hAAA);
    // partial calibration leaves the centers alone
    send_item(KIND_CAL, 12'd4095, 12'd0);
    send_item(KIND_CAL, 12'd0, 12'd4095);
    send_item(KIND_CAL, 12'd1234, 12'd3000);
    send_item(KIND_UPDATE, 12'd2200, 12'd1900);
    // positive side with no travel past the dead band
    apply_settings(64, 2112, 0);
    send_item(KIND_UPDATE, 12'd3000, 12'd4095);
    send_item(KIND_UPDATE, 12'd2100, 12'd1000);
    apply_settings(64, ADC_MAX, 1983);
    send_item(KIND_UPDATE, 12'd4095, 12'd2113);
    // positive span below zero
    apply_settings(64, 2000, 0);
    send_item(KIND_UPDATE, 12'd2500, 12'd100);
    apply_settings(0, ADC_MAX, 0);
    send_item(KIND_UPDATE, 12'd2049, 12'd2047);
    send_item(KIND_UPDATE, 12'd2048, 12'd2048);
    apply_settings(ADC_MAX, ADC_MAX, ADC_MAX);
    send_item(KIND_UPDATE, 12'd0, 12'd4095);
    settle();
    write_reg(CFG_UNUSED, ADC_MAX);
    cfg_valid <= 1'b0;
    send_item(KIND_UPDATE, 12'd4095, 12'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) apply_settings(0, ADC_MAX, 0);
      else if (phase == 1) apply_settings(0, 0, ADC_MAX);
      else apply_settings(pick_reg(0, 400), pick_reg(3200, ADC_MAX), pick_reg(0, 500));
      steady = (phase % 3 == 1);
      count = 0;
      while (count < PHASE_ITEMS) begin
        if (phase == 3 && !paused && count >= PHASE_ITEMS / 2) begin
          settle();
          paused = 1'b1;
        end
        case ($urandom_range(0, 9))
          0: begin
            // a calibration set around a random rest point, sometimes cut short
            case ($urandom_range(0, 5))
              0:       rest_x = $urandom_range(0, 200);
              1:       rest_x = $urandom_range(ADC_MAX - 200, ADC_MAX);
              default: rest_x = $urandom_range(MID - 350, MID + 350);
            endcase
            case ($urandom_range(0, 5))
              0:       rest_y = $urandom_range(0, 200);
              1:       rest_y = $urandom_range(ADC_MAX - 200, ADC_MAX);
              default: rest_y = $urandom_range(MID - 350, MID + 350);
            endcase
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, CAL_SAMPLES - 1)
                                            : CAL_SAMPLES;
            repeat (n) begin
              send_item(KIND_CAL, to_sample(rest_x + $urandom_range(0, 30) - 15),
                        to_sample(rest_y + $urandom_range(0, 30) - 15));
            end
            count += n;
          end
          9: begin
            n = $urandom_range(1, 4);
            repeat (n) begin
              send_item(logic'($urandom_range(0, 1)), ADC_BITS'($urandom_range(0, ADC_MAX)),
                        ADC_BITS'($urandom_range(0, ADC_MAX)));
            end
            count += n;
          end
          default: begin
            n = $urandom_range(3, 10);
            repeat (n) send_item(KIND_UPDATE, pick_sample(rest_x), pick_sample(rest_y));
            count += n;
          end
        endcase
      end
    end

    steady = 1'b0;
    settle();
    $display("run covered %0d input beats (%0d calibration) over %0d register settings",
             beats, cal_beats, settings);
    $display("%0d output beats compared, %0d failures", results, fails);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
